// File: hw/rtl/lpcp_pkg.sv
// ---------------------------------------------------------------------------
// lpcp_pkg
// Shared widths, types and register codes for the closest-point pipeline.
// ---------------------------------------------------------------------------
package lpcp_pkg;

    localparam int FRAC_BITS = 16;
    localparam int POS_W     = 32;
    localparam int DIR_W     = 18;
    localparam int W_W       = POS_W + 1;
    localparam int DDOT_W    = 2 * DIR_W + 2;
    localparam int WDOT_W    = DIR_W + W_W + 2;
    localparam int DD_W      = FRAC_BITS + 2;
    localparam int DP_W      = WDOT_W + 1 - FRAC_BITS;
    localparam int NUM_W     = DP_W + DD_W + 1;
    localparam int DEN_W     = FRAC_BITS + 1;
    localparam int T_W       = 46;
    localparam int RAD_W     = 31;
    localparam int THR_W     = 17;
    localparam int CFG_W     = 31;
    localparam int CFG_IDX_W = 1;
    localparam int DIV_STEPS = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RADIUS             = 1'b0,
        REG_PARALLEL_THRESHOLD = 1'b1
    } cfg_index_t;

    typedef struct packed {
        logic [2:0][POS_W-1:0] pa;
        logic [2:0][POS_W-1:0] pb;
        logic [2:0][DIR_W-1:0] da;
        logic [2:0][DIR_W-1:0] db;
        logic                  ok;
    } side_t;

    typedef struct packed {
        logic [DEN_W-1:0] rem_a;
        logic [DEN_W-1:0] rem_b;
        logic [NUM_W-1:0] nq_a;
        logic [NUM_W-1:0] nq_b;
        logic             neg_a;
        logic             neg_b;
        logic [DEN_W-1:0] den;
        side_t            side;
    } div_word_t;

endpackage

// File: hw/rtl/lpcp_in_if.sv
// ---------------------------------------------------------------------------
// lpcp_in_if
// Input channel: one pair of lines per word.
// ---------------------------------------------------------------------------
interface lpcp_in_if;
    import lpcp_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [POS_W-1:0] line_a_pos_x;
    logic signed [POS_W-1:0] line_a_pos_y;
    logic signed [POS_W-1:0] line_a_pos_z;
    logic signed [DIR_W-1:0] line_a_dir_x;
    logic signed [DIR_W-1:0] line_a_dir_y;
    logic signed [DIR_W-1:0] line_a_dir_z;
    logic signed [POS_W-1:0] line_b_pos_x;
    logic signed [POS_W-1:0] line_b_pos_y;
    logic signed [POS_W-1:0] line_b_pos_z;
    logic signed [DIR_W-1:0] line_b_dir_x;
    logic signed [DIR_W-1:0] line_b_dir_y;
    logic signed [DIR_W-1:0] line_b_dir_z;

    modport source (
        output valid, line_a_pos_x, line_a_pos_y, line_a_pos_z,
               line_a_dir_x, line_a_dir_y, line_a_dir_z,
               line_b_pos_x, line_b_pos_y, line_b_pos_z,
               line_b_dir_x, line_b_dir_y, line_b_dir_z,
        input  ready
    );

    modport sink (
        input  valid, line_a_pos_x, line_a_pos_y, line_a_pos_z,
               line_a_dir_x, line_a_dir_y, line_a_dir_z,
               line_b_pos_x, line_b_pos_y, line_b_pos_z,
               line_b_dir_x, line_b_dir_y, line_b_dir_z,
        output ready
    );

endinterface

// File: hw/rtl/lpcp_out_if.sv
// ---------------------------------------------------------------------------
// lpcp_out_if
// Output channel: closest points and flags per word.
// ---------------------------------------------------------------------------
interface lpcp_out_if;
    import lpcp_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [POS_W-1:0] point_a_x;
    logic signed [POS_W-1:0] point_a_y;
    logic signed [POS_W-1:0] point_a_z;
    logic signed [POS_W-1:0] point_b_x;
    logic signed [POS_W-1:0] point_b_y;
    logic signed [POS_W-1:0] point_b_z;
    logic                    valid_res;
    logic                    within_radius;

    modport source (
        output valid, point_a_x, point_a_y, point_a_z,
               point_b_x, point_b_y, point_b_z, valid_res, within_radius,
        input  ready
    );

    modport sink (
        input  valid, point_a_x, point_a_y, point_a_z,
               point_b_x, point_b_y, point_b_z, valid_res, within_radius,
        output ready
    );

endinterface

// File: hw/rtl/lpcp_div.sv
// ---------------------------------------------------------------------------
// lpcp_div
// Pipelined restoring divider, two quotients over one shared divisor.
// ---------------------------------------------------------------------------
module lpcp_div #(
    parameter int STEPS = lpcp_pkg::DIV_STEPS
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  lpcp_pkg::div_word_t in_word,
    output logic                out_valid,
    output lpcp_pkg::div_word_t out_word
);
    import lpcp_pkg::*;

    localparam int NSTG = (NUM_W + STEPS - 1) / STEPS;

    div_word_t       word_reg  [NSTG];
    div_word_t       word_next [NSTG];
    logic [NSTG-1:0] valid_reg;
    logic [NSTG-1:0] valid_next;

    function automatic div_word_t div_step(input div_word_t w);
        logic [DEN_W:0] ta;
        logic [DEN_W:0] tb;
        div_word_t      r;
        r      = w;
        ta     = {w.rem_a, w.nq_a[NUM_W-1]};
        tb     = {w.rem_b, w.nq_b[NUM_W-1]};
        r.nq_a = {w.nq_a[NUM_W-2:0], 1'b0};
        r.nq_b = {w.nq_b[NUM_W-2:0], 1'b0};
        if (ta >= {1'b0, w.den})
        begin
            r.rem_a   = DEN_W'(ta - {1'b0, w.den});
            r.nq_a[0] = 1'b1;
        end
        else
        begin
            r.rem_a = ta[DEN_W-1:0];
        end
        if (tb >= {1'b0, w.den})
        begin
            r.rem_b   = DEN_W'(tb - {1'b0, w.den});
            r.nq_b[0] = 1'b1;
        end
        else
        begin
            r.rem_b = tb[DEN_W-1:0];
        end
        return r;
    endfunction

    always_comb
    begin
        for (int g = 0; g < NSTG; g++)
        begin
            word_next[g]  = (g == 0) ? in_word : word_reg[(g == 0) ? 0 : g - 1];
            valid_next[g] = (g == 0) ? in_valid : valid_reg[(g == 0) ? 0 : g - 1];
            for (int k = 0; k < STEPS; k++)
            begin
                if (g * STEPS + k < NUM_W)
                begin
                    word_next[g] = div_step(word_next[g]);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int g = 0; g < NSTG; g++)
            begin
                word_reg[g] <= word_next[g];
            end
        end
    end

    assign out_valid = valid_reg[NSTG-1];
    assign out_word  = word_reg[NSTG-1];

`ifndef SYNTHESIS
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(valid_reg))
        else $error("divider advanced while held");
    a_rem_a: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_word.rem_a < out_word.den)
        else $error("remainder a not below divisor");
    a_rem_b: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_word.rem_b < out_word.den)
        else $error("remainder b not below divisor");
`endif

endmodule

// File: hw/rtl/line_pair_closest_points.sv
// ---------------------------------------------------------------------------
// line_pair_closest_points
// Closest points between two 3D lines in Q16.16, with parallel and
// within-radius flags.
// ---------------------------------------------------------------------------
//  channel   | dir | handshake     | payload
//  lines     | in  | valid / ready | two lines: position and unit direction
//  points    | out | valid / ready | two closest points, valid_res, within_radius
//  cfg       | in  | cfg_we        | cfg_index, cfg_data
//
//  One word enters per cycle while the output queue has room. The divider
//  adds ceil(57 / DIV_STEPS) stages (15 stages at DIV_STEPS = 4) to the pipe;
//  it is a restoring divider that resolves DIV_STEPS quotient bits per stage.
//  A two-entry output queue holds results; the whole pipe holds while it is
//  full. Reset clears valid bits and the queue; no clearing pass.
// ---------------------------------------------------------------------------
module line_pair_closest_points #(
    parameter int DIV_STEPS = lpcp_pkg::DIV_STEPS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [lpcp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [lpcp_pkg::CFG_W-1:0]     cfg_data,
    lpcp_in_if.sink                        lines,
    lpcp_out_if.source                     points
);
    import lpcp_pkg::*;

    localparam int HALF  = 1 << (FRAC_BITS - 1);
    localparam int ONE   = 1 << FRAC_BITS;
    localparam int PR_W  = T_W + DIR_W;
    localparam int PQ_W  = PR_W + 1;
    localparam int SQ_W  = 2 * (POS_W - 1);
    localparam logic signed [2*DD_W-1:0] ONE_SQ = (2*DD_W)'(1) << (2 * FRAC_BITS);
    localparam logic [T_W-1:0]           T_MAX  = {1'b0, {(T_W-1){1'b1}}};
    localparam logic signed [PQ_W-1:0]   P_MAX  = PQ_W'({1'b0, {(POS_W-1){1'b1}}});
    localparam logic signed [PQ_W-1:0]   P_MIN  = ~P_MAX;

    typedef struct packed {
        logic [2:0][POS_W-1:0] qa;
        logic [2:0][POS_W-1:0] qb;
        logic                  ok;
        logic                  near;
    } res_t;

    logic             en;
    logic [RAD_W-1:0] radius_reg;
    logic [THR_W-1:0] thr_reg;

    side_t                   s1_side_next, s1_side_reg;
    logic signed [W_W-1:0]   s1_w_next [3];
    logic signed [W_W-1:0]   s1_w_reg  [3];
    logic                    s1_v_reg;

    side_t                          s2_side_reg;
    logic signed [2*DIR_W-1:0]      s2_pdd_next [3], s2_pdd_reg [3];
    logic signed [DIR_W+W_W-1:0]    s2_pwa_next [3], s2_pwa_reg [3];
    logic signed [DIR_W+W_W-1:0]    s2_pwb_next [3], s2_pwb_reg [3];
    logic                           s2_v_reg;

    side_t                   s3_side_reg;
    logic signed [DD_W-1:0]  s3_dd_next, s3_dd_reg;
    logic signed [DP_W-1:0]  s3_dpa_next, s3_dpa_reg;
    logic signed [DP_W-1:0]  s3_dpb_next, s3_dpb_reg;
    logic                    s3_v_reg;

    side_t                        s4_side_reg;
    logic signed [2*DD_W-1:0]     s4_dd2_next, s4_dd2_reg;
    logic signed [DP_W+DD_W-1:0]  s4_padd_next, s4_padd_reg;
    logic signed [DP_W+DD_W-1:0]  s4_pbdd_next, s4_pbdd_reg;
    logic signed [DP_W-1:0]       s4_dpa_reg, s4_dpb_reg;
    logic                         s4_v_reg;

    side_t                   s5_side_next, s5_side_reg;
    logic signed [NUM_W-1:0] s5_na_next, s5_na_reg;
    logic signed [NUM_W-1:0] s5_nb_next, s5_nb_reg;
    logic [DEN_W-1:0]        s5_delta_next, s5_delta_reg;
    logic                    s5_v_reg;

    div_word_t div_in, div_out;
    logic      div_v;

    side_t                 s7_side_reg;
    logic signed [T_W-1:0] s7_ta_next, s7_ta_reg;
    logic signed [T_W-1:0] s7_tb_next, s7_tb_reg;
    logic                  s7_v_reg;

    side_t                  s8_side_reg;
    logic signed [PR_W-1:0] s8_pa_next [3], s8_pa_reg [3];
    logic signed [PR_W-1:0] s8_pb_next [3], s8_pb_reg [3];
    logic                   s8_v_reg;

    res_t s9_res_next, s9_res_reg;
    logic s9_v_reg;

    res_t               s10_res_reg;
    logic [POS_W-2:0]   s10_mag_next [3], s10_mag_reg [3];
    logic               s10_big_next, s10_big_reg;
    logic               s10_v_reg;

    res_t              s11_res_reg;
    logic [SQ_W-1:0]   s11_sq_next [3], s11_sq_reg [3];
    logic [SQ_W-1:0]   s11_r2_next, s11_r2_reg;
    logic              s11_big_reg;
    logic              s11_v_reg;

    logic [SQ_W+1:0] dist2;
    res_t            fin_res;
    res_t            fifo_reg [2];
    logic            wr_ptr_reg, rd_ptr_reg;
    logic [1:0]      cnt_reg;
    logic            push, pop;
    res_t            head;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= '0;
            thr_reg    <= THR_W'(1);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                REG_RADIUS:             radius_reg <= cfg_data[RAD_W-1:0];
                REG_PARALLEL_THRESHOLD: thr_reg    <= cfg_data[THR_W-1:0];
                default:                ;
            endcase
        end
    end

    assign en          = (cnt_reg != 2'd2);
    assign lines.ready = en;

    // stage 1: unpack, w = pa - pb
    always_comb
    begin
        s1_side_next.pa = {lines.line_a_pos_z, lines.line_a_pos_y, lines.line_a_pos_x};
        s1_side_next.pb = {lines.line_b_pos_z, lines.line_b_pos_y, lines.line_b_pos_x};
        s1_side_next.da = {lines.line_a_dir_z, lines.line_a_dir_y, lines.line_a_dir_x};
        s1_side_next.db = {lines.line_b_dir_z, lines.line_b_dir_y, lines.line_b_dir_x};
        s1_side_next.ok = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            s1_w_next[i] = W_W'($signed(s1_side_next.pa[i]))
                         - W_W'($signed(s1_side_next.pb[i]));
        end
    end

    // stage 2: dot-product terms
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            s2_pdd_next[i] = $signed(s1_side_reg.da[i]) * $signed(s1_side_reg.db[i]);
            s2_pwa_next[i] = $signed(s1_side_reg.da[i]) * s1_w_reg[i];
            s2_pwb_next[i] = $signed(s1_side_reg.db[i]) * s1_w_reg[i];
        end
    end

    // stage 3: sums, round, clamp dd
    always_comb
    begin
        logic signed [DDOT_W:0] ddr;
        logic signed [WDOT_W:0] dar;
        logic signed [WDOT_W:0] dbr;
        ddr = (DDOT_W+1)'(HALF);
        dar = (WDOT_W+1)'(HALF);
        dbr = (WDOT_W+1)'(HALF);
        for (int i = 0; i < 3; i++)
        begin
            ddr = ddr + (DDOT_W+1)'(s2_pdd_reg[i]);
            dar = dar + (WDOT_W+1)'(s2_pwa_reg[i]);
            dbr = dbr + (WDOT_W+1)'(s2_pwb_reg[i]);
        end
        ddr = ddr >>> FRAC_BITS;
        if (ddr > (DDOT_W+1)'(ONE))
        begin
            s3_dd_next = DD_W'(ONE);
        end
        else if (ddr < (DDOT_W+1)'(-ONE))
        begin
            s3_dd_next = DD_W'(-ONE);
        end
        else
        begin
            s3_dd_next = DD_W'(ddr);
        end
        s3_dpa_next = DP_W'(dar >>> FRAC_BITS);
        s3_dpb_next = DP_W'(dbr >>> FRAC_BITS);
    end

    // stage 4: products with dd
    always_comb
    begin
        s4_dd2_next  = s3_dd_reg * s3_dd_reg;
        s4_padd_next = s3_dpa_reg * s3_dd_reg;
        s4_pbdd_next = s3_dpb_reg * s3_dd_reg;
    end

    // stage 5: delta, numerators, parallel test
    always_comb
    begin
        logic signed [2*DD_W-1:0] dl;
        dl            = ONE_SQ - s4_dd2_reg + (2*DD_W)'(HALF);
        s5_delta_next = dl[FRAC_BITS +: DEN_W];
        s5_na_next    = NUM_W'(s4_pbdd_reg) - (NUM_W'(s4_dpa_reg) <<< FRAC_BITS);
        s5_nb_next    = (NUM_W'(s4_dpb_reg) <<< FRAC_BITS) - NUM_W'(s4_padd_reg);
        s5_side_next    = s4_side_reg;
        s5_side_next.ok = (s5_delta_next != '0) && (s5_delta_next >= thr_reg);
    end

    always_comb
    begin
        div_in.rem_a = '0;
        div_in.rem_b = '0;
        div_in.neg_a = s5_na_reg[NUM_W-1];
        div_in.neg_b = s5_nb_reg[NUM_W-1];
        div_in.nq_a  = div_in.neg_a ? NUM_W'(-s5_na_reg) : NUM_W'(s5_na_reg);
        div_in.nq_b  = div_in.neg_b ? NUM_W'(-s5_nb_reg) : NUM_W'(s5_nb_reg);
        div_in.den   = s5_side_reg.ok ? s5_delta_reg : DEN_W'(1);
        div_in.side  = s5_side_reg;
    end

    lpcp_div #(
        .STEPS (DIV_STEPS)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s5_v_reg),
        .in_word   (div_in),
        .out_valid (div_v),
        .out_word  (div_out)
    );

    // stage 7: sign and clamp quotients
    always_comb
    begin
        logic [T_W-1:0] sa;
        logic [T_W-1:0] sb;
        sa = (div_out.nq_a > NUM_W'(T_MAX)) ? T_MAX : div_out.nq_a[T_W-1:0];
        sb = (div_out.nq_b > NUM_W'(T_MAX)) ? T_MAX : div_out.nq_b[T_W-1:0];
        s7_ta_next = div_out.neg_a ? -$signed(sa) : $signed(sa);
        s7_tb_next = div_out.neg_b ? -$signed(sb) : $signed(sb);
    end

    // stage 8: t * dir
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            s8_pa_next[i] = s7_ta_reg * $signed(s7_side_reg.da[i]);
            s8_pb_next[i] = s7_tb_reg * $signed(s7_side_reg.db[i]);
        end
    end

    // stage 9: round, add position, saturate
    always_comb
    begin
        logic signed [PQ_W-1:0] qa;
        logic signed [PQ_W-1:0] qb;
        s9_res_next.ok   = s8_side_reg.ok;
        s9_res_next.near = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            qa = ((PQ_W'(s8_pa_reg[i]) + PQ_W'(HALF)) >>> FRAC_BITS)
               + PQ_W'($signed(s8_side_reg.pa[i]));
            qb = ((PQ_W'(s8_pb_reg[i]) + PQ_W'(HALF)) >>> FRAC_BITS)
               + PQ_W'($signed(s8_side_reg.pb[i]));
            qa = (qa > P_MAX) ? P_MAX : ((qa < P_MIN) ? P_MIN : qa);
            qb = (qb > P_MAX) ? P_MAX : ((qb < P_MIN) ? P_MIN : qb);
            s9_res_next.qa[i] = s8_side_reg.ok ? qa[POS_W-1:0] : '0;
            s9_res_next.qb[i] = s8_side_reg.ok ? qb[POS_W-1:0] : '0;
        end
    end

    // stage 10: differences
    always_comb
    begin
        logic signed [W_W-1:0] d;
        logic [W_W-1:0]        m;
        s10_big_next = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            d = W_W'($signed(s9_res_reg.qa[i])) - W_W'($signed(s9_res_reg.qb[i]));
            m = d[W_W-1] ? W_W'(-d) : W_W'(d);
            s10_mag_next[i] = m[POS_W-2:0];
            s10_big_next    = s10_big_next | (m[W_W-1:POS_W-1] != '0);
        end
    end

    // stage 11: squares
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            s11_sq_next[i] = SQ_W'(s10_mag_reg[i] * s10_mag_reg[i]);
        end
        s11_r2_next = SQ_W'(radius_reg * radius_reg);
    end

    always_comb
    begin
        dist2 = (SQ_W+2)'(s11_sq_reg[0]) + (SQ_W+2)'(s11_sq_reg[1])
              + (SQ_W+2)'(s11_sq_reg[2]);
        fin_res      = s11_res_reg;
        fin_res.near = s11_res_reg.ok && !s11_big_reg
                     && (dist2 <= (SQ_W+2)'(s11_r2_reg));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg  <= 1'b0;
            s2_v_reg  <= 1'b0;
            s3_v_reg  <= 1'b0;
            s4_v_reg  <= 1'b0;
            s5_v_reg  <= 1'b0;
            s7_v_reg  <= 1'b0;
            s8_v_reg  <= 1'b0;
            s9_v_reg  <= 1'b0;
            s10_v_reg <= 1'b0;
            s11_v_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_v_reg  <= lines.valid;
            s2_v_reg  <= s1_v_reg;
            s3_v_reg  <= s2_v_reg;
            s4_v_reg  <= s3_v_reg;
            s5_v_reg  <= s4_v_reg;
            s7_v_reg  <= div_v;
            s8_v_reg  <= s7_v_reg;
            s9_v_reg  <= s8_v_reg;
            s10_v_reg <= s9_v_reg;
            s11_v_reg <= s10_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_side_reg  <= s1_side_next;
            s1_w_reg     <= s1_w_next;
            s2_side_reg  <= s1_side_reg;
            s2_pdd_reg   <= s2_pdd_next;
            s2_pwa_reg   <= s2_pwa_next;
            s2_pwb_reg   <= s2_pwb_next;
            s3_side_reg  <= s2_side_reg;
            s3_dd_reg    <= s3_dd_next;
            s3_dpa_reg   <= s3_dpa_next;
            s3_dpb_reg   <= s3_dpb_next;
            s4_side_reg  <= s3_side_reg;
            s4_dd2_reg   <= s4_dd2_next;
            s4_padd_reg  <= s4_padd_next;
            s4_pbdd_reg  <= s4_pbdd_next;
            s4_dpa_reg   <= s3_dpa_reg;
            s4_dpb_reg   <= s3_dpb_reg;
            s5_side_reg  <= s5_side_next;
            s5_na_reg    <= s5_na_next;
            s5_nb_reg    <= s5_nb_next;
            s5_delta_reg <= s5_delta_next;
            s7_side_reg  <= div_out.side;
            s7_ta_reg    <= s7_ta_next;
            s7_tb_reg    <= s7_tb_next;
            s8_side_reg  <= s7_side_reg;
            s8_pa_reg    <= s8_pa_next;
            s8_pb_reg    <= s8_pb_next;
            s9_res_reg   <= s9_res_next;
            s10_res_reg  <= s9_res_reg;
            s10_mag_reg  <= s10_mag_next;
            s10_big_reg  <= s10_big_next;
            s11_res_reg  <= s10_res_reg;
            s11_sq_reg   <= s11_sq_next;
            s11_r2_reg   <= s11_r2_next;
            s11_big_reg  <= s10_big_reg;
        end
    end

    // output queue
    assign push = en && s11_v_reg;
    assign pop  = points.valid && points.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wr_ptr_reg] <= fin_res;
        end
    end

    assign head                 = fifo_reg[rd_ptr_reg];
    assign points.valid         = (cnt_reg != 2'd0);
    assign points.point_a_x     = head.qa[0];
    assign points.point_a_y     = head.qa[1];
    assign points.point_a_z     = head.qa[2];
    assign points.point_b_x     = head.qb[0];
    assign points.point_b_y     = head.qb[1];
    assign points.point_b_z     = head.qb[2];
    assign points.valid_res     = head.ok;
    assign points.within_radius = head.near;

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> cnt_reg != 2'd2)
        else $error("output queue overflow");
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        pop && !push |=> cnt_reg == $past(cnt_reg) - 2'd1)
        else $error("queue count lost a word");
    a_parallel_zero: assert property (@(posedge clk) disable iff (!rst_n)
        points.valid && !points.valid_res |->
            !points.within_radius && points.point_a_x == '0 && points.point_b_z == '0)
        else $error("parallel result not cleared");
`endif

endmodule

// File: bench/line_pair_closest_points_check.sv
// ---------------------------------------------------------------------------
// line_pair_closest_points_check
// Watches the line and point channels and the register writes, computes
// the closest points of every accepted line pair and compares each
// returned word field by field, in order.
// ---------------------------------------------------------------------------
module line_pair_closest_points_check (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [lpcp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [lpcp_pkg::CFG_W-1:0]     cfg_data,
    lpcp_in_if.sink                        lines,
    lpcp_out_if.sink                       points,
    output int                             fail_count,
    output int                             pending,
    output int                             accepted
);
    timeunit 1ns;
    timeprecision 1ps;
    import lpcp_pkg::*;

    typedef struct packed {
        logic signed [POS_W-1:0] ax, ay, az, bx, by, bz;
        logic                    ok;
        logic                    near;
    } closest_t;

    localparam longint ONE   = 64'sd1 <<< FRAC_BITS;
    localparam longint T_MAX = (64'sd1 <<< 45) - 1;

    logic [RAD_W-1:0] radius_q;
    logic [THR_W-1:0] threshold_q;
    closest_t         points_due[$];

    function automatic longint rnd(longint x);
        return (x + (ONE >>> 1)) >>> FRAC_BITS;
    endfunction

    function automatic longint lim(longint x, longint lo, longint hi);
        return x < lo ? lo : (x > hi ? hi : x);
    endfunction

    function automatic longint mag2(longint d);
        longint m;
        m = d < 0 ? -d : d;
        return m * m;
    endfunction

    function automatic closest_t solve_pair(
        longint pa[3], longint pb[3], longint va[3], longint vb[3]);
        closest_t r;
        longint ddf, daf, dbf, dd, delta, dpa, dpb, ta, tb, qa[3], qb[3];
        longint unsigned dist_acc, sq, r2;
        ddf = 0; daf = 0; dbf = 0; dist_acc = 0;
        r = '0;
        for (int i = 0; i < 3; i++)
        begin
            ddf += va[i] * vb[i];
            daf += va[i] * (pa[i] - pb[i]);
            dbf += vb[i] * (pa[i] - pb[i]);
        end
        dd = lim(rnd(ddf), -ONE, ONE);
        delta = rnd(ONE * ONE - dd * dd);
        if (delta == 0 || delta < longint'(threshold_q))
            return r;
        dpa = rnd(daf);
        dpb = rnd(dbf);
        ta = lim((dpb * dd - dpa * ONE) / delta, -T_MAX, T_MAX);
        tb = lim((dpb * ONE - dpa * dd) / delta, -T_MAX, T_MAX);
        for (int i = 0; i < 3; i++)
        begin
            qa[i] = lim(pa[i] + rnd(ta * va[i]), -64'sd2147483648, 64'sd2147483647);
            qb[i] = lim(pb[i] + rnd(tb * vb[i]), -64'sd2147483648, 64'sd2147483647);
            sq = mag2(qa[i] - qb[i]);
            dist_acc = (dist_acc + sq < dist_acc) ? 64'hFFFF_FFFF_FFFF_FFFF
                                                  : dist_acc + sq;
        end
        r2 = longint'(radius_q) * longint'(radius_q);
        r.ax = POS_W'(qa[0]); r.ay = POS_W'(qa[1]); r.az = POS_W'(qa[2]);
        r.bx = POS_W'(qb[0]); r.by = POS_W'(qb[1]); r.bz = POS_W'(qb[2]);
        r.ok = 1'b1;
        r.near = dist_acc <= r2;
        return r;
    endfunction

    task automatic compare(string name, longint want, longint got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        closest_t e;
        longint pa[3], pb[3], va[3], vb[3];
        if (!rst_n)
        begin
            radius_q    <= '0;
            threshold_q <= THR_W'(1);
            points_due.delete();
            fail_count  = 0;
            pending     = 0;
            accepted    = 0;
        end
        else
        begin
            if (points.valid && points.ready)
            begin
                if (points_due.size() == 0)
                begin
                    $error("point word with nothing expected");
                    fail_count++;
                end
                else
                begin
                    e = points_due.pop_front();
                    compare("point_a_x", e.ax, points.point_a_x);
                    compare("point_a_y", e.ay, points.point_a_y);
                    compare("point_a_z", e.az, points.point_a_z);
                    compare("point_b_x", e.bx, points.point_b_x);
                    compare("point_b_y", e.by, points.point_b_y);
                    compare("point_b_z", e.bz, points.point_b_z);
                    compare("valid_res", e.ok, points.valid_res);
                    compare("within_radius", e.near, points.within_radius);
                end
            end
            if (lines.valid && lines.ready)
            begin
                pa = '{lines.line_a_pos_x, lines.line_a_pos_y, lines.line_a_pos_z};
                pb = '{lines.line_b_pos_x, lines.line_b_pos_y, lines.line_b_pos_z};
                va = '{lines.line_a_dir_x, lines.line_a_dir_y, lines.line_a_dir_z};
                vb = '{lines.line_b_dir_x, lines.line_b_dir_y, lines.line_b_dir_z};
                points_due.push_back(solve_pair(pa, pb, va, vb));
                accepted++;
            end
            if (cfg_we)
            begin
                if (cfg_index == REG_RADIUS)
                    radius_q <= cfg_data[RAD_W-1:0];
                else if (cfg_index == REG_PARALLEL_THRESHOLD)
                    threshold_q <= cfg_data[THR_W-1:0];
            end
            pending = points_due.size();
        end
    end
endmodule

// File: bench/line_pair_closest_points_test.sv
// ---------------------------------------------------------------------------
// line_pair_closest_points_test
// Drives directed and random line pairs under several radius and parallel
// threshold settings with random gaps on both channels; the checker
// predicts and compares, this module gives the verdict.
// ---------------------------------------------------------------------------
module line_pair_closest_points_test;
    timeunit 1ns;
    timeprecision 1ps;
    import lpcp_pkg::*;

    localparam int DRAIN = 80;
    localparam int STALL_LIMIT = 5000;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    int                   fail_count, pending, accepted, quiet;
    int                   pairs_sent;

    lpcp_in_if  lines();
    lpcp_out_if points();

    line_pair_closest_points i_dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .lines(lines), .points(points)
    );

    line_pair_closest_points_check i_check (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .lines(lines), .points(points),
        .fail_count(fail_count), .pending(pending), .accepted(accepted)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    initial
    begin
        points.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            points.ready <= gap_len() == 0;
        end
    end

    initial
    begin
        quiet = 0;
        forever
        begin
            @(posedge clk);
            if ((lines.valid && lines.ready) || (points.valid && points.ready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= STALL_LIMIT)
            begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    function automatic logic [POS_W-1:0] any_pos();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return $urandom;
            default: return 32'(signed'($urandom_range(0, 1 << 25)) - (1 << 24));
        endcase
    endfunction

    // Approximately unit vector: one big component and two small ones,
    // occasionally raw random bits.
    task automatic any_dir(output logic [DIR_W-1:0] d[3]);
        int k, s;
        k = $urandom_range(0, 2);
        for (int i = 0; i < 3; i++)
        begin
            s = $urandom_range(0, 1) ? 1 : -1;
            if ($urandom_range(0, 15) == 0)
                d[i] = DIR_W'($urandom);
            else if (i == k)
                d[i] = 18'(s * $urandom_range(40000, 65536));
            else
                d[i] = 18'(s * $urandom_range(0, 37000));
        end
    endtask

    task automatic send_pair(logic [POS_W-1:0] pa[3], logic [DIR_W-1:0] va[3],
                             logic [POS_W-1:0] pb[3], logic [DIR_W-1:0] vb[3]);
        int g;
        g = gap_len();
        if (g > 0)
        begin
            lines.valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        lines.valid <= 1'b1;
        lines.line_a_pos_x <= pa[0]; lines.line_a_pos_y <= pa[1];
        lines.line_a_pos_z <= pa[2];
        lines.line_a_dir_x <= va[0]; lines.line_a_dir_y <= va[1];
        lines.line_a_dir_z <= va[2];
        lines.line_b_pos_x <= pb[0]; lines.line_b_pos_y <= pb[1];
        lines.line_b_pos_z <= pb[2];
        lines.line_b_dir_x <= vb[0]; lines.line_b_dir_y <= vb[1];
        lines.line_b_dir_z <= vb[2];
        do @(posedge clk); while (!lines.ready);
        pairs_sent++;
    endtask

    task automatic settle();
        lines.valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (DRAIN) @(posedge clk);
    endtask

    task automatic write_reg(cfg_index_t idx, logic [CFG_W-1:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic random_pair(bit parallel);
        logic [POS_W-1:0] pa[3], pb[3];
        logic [DIR_W-1:0] va[3], vb[3];
        for (int i = 0; i < 3; i++)
        begin
            pa[i] = any_pos();
            pb[i] = any_pos();
        end
        any_dir(va);
        if (parallel)
            for (int i = 0; i < 3; i++)
                vb[i] = $urandom_range(0, 1) ? va[i] : -va[i];
        else
            any_dir(vb);
        send_pair(pa, va, pb, vb);
    endtask

    logic [POS_W-1:0] p0[3], p1[3];
    logic [DIR_W-1:0] ex[3], ey[3], ez[3], en[3], eb[3];
    logic [CFG_W-1:0] radii[5];
    logic [CFG_W-1:0] thresholds[5];

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_RADIUS;
        cfg_data = '0;
        pairs_sent = 0;
        lines.valid = 1'b0;
        lines.line_a_pos_x = '0; lines.line_a_pos_y = '0; lines.line_a_pos_z = '0;
        lines.line_a_dir_x = '0; lines.line_a_dir_y = '0; lines.line_a_dir_z = '0;
        lines.line_b_pos_x = '0; lines.line_b_pos_y = '0; lines.line_b_pos_z = '0;
        lines.line_b_dir_x = '0; lines.line_b_dir_y = '0; lines.line_b_dir_z = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        ex = '{18'sd65536, 0, 0};
        ey = '{0, 18'sd65536, 0};
        ez = '{0, 0, 18'sd65536};
        en = '{-18'sd65536, 0, 0};
        eb = '{18'h1FFFF, 18'h20000, 18'h1FFFF};
        p0 = '{0, 0, 0};
        p1 = '{32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000};

        send_pair(p0, ex, p1, ey);
        send_pair(p1, ex, p0, ez);
        send_pair(p0, ex, p1, ex);
        send_pair(p0, ex, p1, en);
        send_pair(p0, eb, p1, ey);
        send_pair(p0, eb, p1, eb);
        p0 = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
        p1 = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF};
        send_pair(p0, ey, p1, ez);
        send_pair(p1, ez, p0, ex);
        send_pair(p0, ex, p1, ey);
        send_pair(p1, ey, p0, en);
        for (int i = 0; i < 10; i++)
            random_pair(i % 3 == 0);
        settle();

        radii = '{31'h7FFF_FFFF, 31'd0, 31'h0001_0000, 31'h0100_0000, 31'h7FFF_FFFF};
        thresholds = '{17'h10000, 17'd0, 17'd1, 17'd600, 17'h10000};
        for (int ph = 0; ph < 5; ph++)
        begin
            write_reg(REG_RADIUS, ph == 4 ? CFG_W'($urandom) : radii[ph]);
            write_reg(REG_PARALLEL_THRESHOLD, thresholds[ph]);
            for (int n = 0; n < 265; n++)
                random_pair($urandom_range(0, 7) == 0);
            settle();
        end

        $display("covered %0d line pairs (%0d seen by the checker) over 6 register",
                 pairs_sent, accepted);
        $display("settings, incl. parallel and saturating cases, with random gaps");
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule

// File: sim.f
hw/rtl/lpcp_pkg.sv
hw/rtl/lpcp_in_if.sv
hw/rtl/lpcp_out_if.sv
hw/rtl/lpcp_div.sv
hw/rtl/line_pair_closest_points.sv
bench/line_pair_closest_points_check.sv
bench/line_pair_closest_points_test.sv
